[rtl/pits_pkg.sv]
// Shared types, constants and key compare for the partial insertion sort top-k block.
package pits_pkg;

  localparam int unsigned MAX_KEPT_DEF = 16;
  localparam int unsigned LIMIT_W      = 5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;
  localparam int unsigned PADDR_W      = 3;
  localparam int unsigned PDATA_W      = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_EMIT   = 2'd1,
    OP_CLEAR  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CMP,
    ST_INS_WR,
    ST_EM_LD,
    ST_EM_WAIT
  } state_e;

  typedef struct packed {
    logic [11:0] record_id;
    logic [7:0]  height;
    logic [7:0]  weight;
    logic [11:0] birth_year;
    logic [63:0] name_key;
  } rec_t;

  function automatic logic key_less(input rec_t a, input rec_t b);
    key_less = (a.birth_year < b.birth_year) ||
               ((a.birth_year == b.birth_year) && (a.name_key < b.name_key));
  endfunction

endpackage

[rtl/pits_if.sv]
// Valid/ready channel interfaces for input items and result words.
interface pits_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [11:0] record_id;
  logic [7:0]  height;
  logic [7:0]  weight;
  logic [11:0] birth_year;
  logic [63:0] name_key;

  modport source (output valid, opcode, record_id, height, weight, birth_year, name_key,
                  input ready);
  modport sink   (input valid, opcode, record_id, height, weight, birth_year, name_key,
                  output ready);
endinterface

interface pits_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_record_id;
  logic [7:0]  out_height;
  logic [7:0]  out_weight;
  logic [11:0] out_birth_year;
  logic [63:0] out_name_key;
  logic        entry_valid;
  logic        last_of_run;

  modport source (output valid, out_record_id, out_height, out_weight, out_birth_year,
                  out_name_key, entry_valid, last_of_run, input ready);
  modport sink   (input valid, out_record_id, out_height, out_weight, out_birth_year,
                  out_name_key, entry_valid, last_of_run, output ready);
endinterface

[rtl/pits_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module pits_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/pits_regs.sv]
// APB-style configuration register holding the kept count limit.
module pits_regs
  import pits_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [LIMIT_W-1:0] limit_o
);

  logic [LIMIT_W-1:0] limit_q, limit_d;
  logic               sel_limit;

  assign sel_limit = (paddr[PADDR_W-1] == 1'b0);
  assign pready    = 1'b1;

  always_comb begin
    limit_d = limit_q;
    if (psel && penable && pwrite && sel_limit) begin
      limit_d = pwdata[LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else begin
      limit_q <= limit_d;
    end
  end

  assign prdata  = sel_limit ? PDATA_W'(limit_q) : '0;
  assign limit_o = limit_q;

endmodule

[rtl/pits_seq.sv]
// Sequencer: insertion walk with one shared key compare, emit and clear.
module pits_seq
  import pits_pkg::*;
#(
  parameter int unsigned MAX_KEPT = MAX_KEPT_DEF,
  parameter int unsigned AW       = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1,
  parameter int unsigned CW       = $clog2(MAX_KEPT + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [LIMIT_W-1:0] limit_i,
  pits_in_if.sink            in_ch_i,
  pits_out_if.source         out_ch_o,
  output logic               ram_we_o,
  output logic [AW-1:0]      ram_waddr_o,
  output rec_t               ram_wdata_o,
  output logic [AW-1:0]      ram_raddr_o,
  input  rec_t               ram_rdata_i
);

  state_e        state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] size_q, size_d;
  logic [AW-1:0] ecnt_q, ecnt_d;
  logic          first_q, first_d;
  logic          ovalid_q, ovalid_d;
  logic          last_q, last_d;
  logic          evalid_q, evalid_d;
  rec_t          new_q, new_d;
  rec_t          orec_q, orec_d;

  logic [CW-1:0] eff_k;
  logic [CW-1:0] count;
  logic          lt;
  rec_t          in_rec;

  always_comb begin
    if (limit_i == '0) begin
      eff_k = CW'(1);
    end else if (int'(limit_i) > int'(MAX_KEPT)) begin
      eff_k = CW'(MAX_KEPT);
    end else begin
      eff_k = CW'(limit_i);
    end
  end

  assign count = (fill_q < eff_k) ? fill_q : eff_k;

  assign in_rec.record_id  = in_ch_i.record_id;
  assign in_rec.height     = in_ch_i.height;
  assign in_rec.weight     = in_ch_i.weight;
  assign in_rec.birth_year = in_ch_i.birth_year;
  assign in_rec.name_key   = in_ch_i.name_key;

  assign lt = key_less(new_q, ram_rdata_i);

  assign in_ch_i.ready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    idx_d       = idx_q;
    size_d      = size_q;
    ecnt_d      = ecnt_q;
    first_d     = first_q;
    ovalid_d    = ovalid_q;
    last_d      = last_q;
    evalid_d    = evalid_q;
    new_d       = new_q;
    orec_d      = orec_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = idx_q[AW-1:0];
    ram_wdata_o = new_q;
    ram_raddr_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_ch_i.valid) begin
          case (op_e'(in_ch_i.opcode))
            OP_INSERT: begin
              new_d   = in_rec;
              idx_d   = count;
              first_d = (count == eff_k);
              fill_d  = (count < eff_k) ? count + CW'(1) : count;
              state_d = (count == '0) ? ST_INS_WR : ST_INS_RD;
            end
            OP_EMIT: begin
              size_d = count;
              ecnt_d = '0;
              if (count == '0) begin
                orec_d   = '0;
                evalid_d = 1'b0;
                last_d   = 1'b1;
                ovalid_d = 1'b1;
                state_d  = ST_EM_WAIT;
              end else begin
                ram_raddr_o = '0;
                state_d     = ST_EM_LD;
              end
            end
            OP_CLEAR: begin
              fill_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_INS_RD: begin
        ram_raddr_o = AW'(idx_q - CW'(1));
        state_d     = ST_INS_CMP;
      end
      ST_INS_CMP: begin
        if (lt) begin
          if (!first_q) begin
            ram_we_o    = 1'b1;
            ram_wdata_o = ram_rdata_i;
          end
          first_d = 1'b0;
          idx_d   = idx_q - CW'(1);
          if (idx_q == CW'(1)) begin
            state_d = ST_INS_WR;
          end else begin
            ram_raddr_o = AW'(idx_q - CW'(2));
          end
        end else begin
          ram_we_o = !first_q;
          state_d  = ST_IDLE;
        end
      end
      ST_INS_WR: begin
        ram_we_o = 1'b1;
        state_d  = ST_IDLE;
      end
      ST_EM_LD: begin
        orec_d   = ram_rdata_i;
        evalid_d = 1'b1;
        last_d   = ((CW'(ecnt_q) + CW'(1)) == size_q);
        ovalid_d = 1'b1;
        state_d  = ST_EM_WAIT;
      end
      ST_EM_WAIT: begin
        if (out_ch_o.ready) begin
          ovalid_d = 1'b0;
          if (last_q) begin
            state_d = ST_IDLE;
          end else begin
            ecnt_d      = ecnt_q + AW'(1);
            ram_raddr_o = ecnt_q + AW'(1);
            state_d     = ST_EM_LD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      idx_q    <= '0;
      size_q   <= '0;
      ecnt_q   <= '0;
      first_q  <= 1'b0;
      ovalid_q <= 1'b0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      idx_q    <= idx_d;
      size_q   <= size_d;
      ecnt_q   <= ecnt_d;
      first_q  <= first_d;
      ovalid_q <= ovalid_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_q    <= new_d;
    orec_q   <= orec_d;
    evalid_q <= evalid_d;
  end

  assign out_ch_o.valid          = ovalid_q;
  assign out_ch_o.out_record_id  = orec_q.record_id;
  assign out_ch_o.out_height     = orec_q.height;
  assign out_ch_o.out_weight     = orec_q.weight;
  assign out_ch_o.out_birth_year = orec_q.birth_year;
  assign out_ch_o.out_name_key   = orec_q.name_key;
  assign out_ch_o.entry_valid    = evalid_q;
  assign out_ch_o.last_of_run    = last_q;

endmodule

[rtl/partial_insertion_sort_top_k.sv]
// Insert: an empty store takes the record at once; else a walk from the tail makes
// one key compare per read of the store, plus a front write when it gets there.
// Emit: each word is loaded, then held until the sink takes it. Clear and unused
// opcodes are done in the idle state. One item is in work at a time.
// Reset: store empty, limit 10; record store contents undefined until written.
module partial_insertion_sort_top_k
  import pits_pkg::*;
#(
  parameter int unsigned MAX_KEPT = MAX_KEPT_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  pits_in_if.sink            in_ch_i,
  pits_out_if.source         out_ch_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

  logic [LIMIT_W-1:0] limit;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [AW-1:0]      ram_raddr;
  rec_t               ram_wdata;
  rec_t               ram_rdata;

  pits_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  pits_ram #(
    .WIDTH ($bits(rec_t)),
    .DEPTH (MAX_KEPT),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pits_seq #(
    .MAX_KEPT (MAX_KEPT),
    .AW       (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .limit_i     (limit),
    .in_ch_i     (in_ch_i),
    .out_ch_o    (out_ch_o),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

endmodule

[tb/tb_top.sv]
// Testbench for the top-k insertion sort block: directed and random records, local store.
`timescale 1ns / 1ps
module tb_top
  import pits_pkg::*;
();

  localparam logic [PADDR_W-1:0] KEPT_LIMIT_ADDR = '0;
  localparam logic [1:0]         OP_UNUSED       = 2'd3;
  localparam int HOLD_OFF      = 2 * MAX_KEPT_DEF + 8;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int RANDOM_ITEMS  = 350;
  localparam int RANDOM_PHASES = 7;

  typedef struct packed {
    rec_t rec;
    logic entry_valid;
    logic last_of_run;
  } word_t;

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  pits_in_if  in_ch ();
  pits_out_if out_ch ();

  partial_insertion_sort_top_k uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch_i  (in_ch),
    .out_ch_o (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  rec_t               kept [MAX_KEPT_DEF];
  int                 kept_fill;
  logic [LIMIT_W-1:0] kept_k;
  word_t              pending_words [$];
  int                 mismatches = 0;
  int                 cycles = 0;
  int                 rx_hold;
  bit                 tx_gaps_on;
  bit                 rx_stalls_on;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic string word_text(word_t w);
    return $sformatf("id %03h ht %02h wt %02h yr %03h name %016h valid %b last %b",
                     w.rec.record_id, w.rec.height, w.rec.weight, w.rec.birth_year,
                     w.rec.name_key, w.entry_valid, w.last_of_run);
  endfunction

  function automatic bit earlier_than(rec_t a, rec_t b);
    return (a.birth_year < b.birth_year) ||
           (a.birth_year == b.birth_year && a.name_key < b.name_key);
  endfunction

  function automatic int kept_limit();
    int kk;
    kk = int'(kept_k);
    if (kk == 0) kk = 1;
    if (kk > MAX_KEPT_DEF) kk = MAX_KEPT_DEF;
    return kk;
  endfunction

  function automatic int kept_count();
    return (kept_fill < kept_limit()) ? kept_fill : kept_limit();
  endfunction

  function automatic void place_record(rec_t r);
    int k;
    int cnt;
    int pos;
    k   = kept_limit();
    cnt = kept_count();
    pos = 0;
    while (pos < cnt && !earlier_than(r, kept[pos])) pos++;
    if (pos >= k) begin
      kept_fill = cnt;
      return;
    end
    for (int i = (cnt < k) ? cnt : k - 1; i > pos; i--) kept[i] = kept[i-1];
    kept[pos] = r;
    kept_fill = (cnt < k) ? cnt + 1 : k;
  endfunction

  function automatic void list_kept_words();
    int cnt;
    cnt = kept_count();
    if (cnt == 0) begin
      pending_words.push_back('{rec: '0, entry_valid: 1'b0, last_of_run: 1'b1});
    end else begin
      for (int i = 0; i < cnt; i++)
        pending_words.push_back('{rec: kept[i], entry_valid: 1'b1,
                                  last_of_run: (i == cnt - 1)});
    end
  endfunction

  function automatic rec_t mk_rec(int id, int ht, int wt, int yr, logic [63:0] name);
    rec_t r;
    r.record_id  = 12'(id);
    r.height     = 8'(ht);
    r.weight     = 8'(wt);
    r.birth_year = 12'(yr);
    r.name_key   = name;
    return r;
  endfunction

  function automatic rec_t rand_rec();
    rec_t r;
    r.record_id = 12'($urandom);
    r.height    = 8'($urandom);
    r.weight    = 8'($urandom);
    r.name_key  = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: r.birth_year = 12'($urandom);
      1: begin
        r.birth_year = 12'($urandom_range(2000, 2003));
        case ($urandom_range(0, 3))
          0: r.name_key = 64'h0;
          1: r.name_key = 64'h7FFF_FFFF_FFFF_FFFF;
          2: r.name_key = 64'h8000_0000_0000_0000;
          default: r.name_key = '1;
        endcase
      end
      2: r.birth_year = 12'($urandom_range(2000, 2003));
      default: r.birth_year = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : result_port
    word_t got;
    word_t want;
    int    n;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      rx_hold      <= 0;
    end else if (out_ch.valid && out_ch.ready) begin
      got.rec.record_id  = out_ch.out_record_id;
      got.rec.height     = out_ch.out_height;
      got.rec.weight     = out_ch.out_weight;
      got.rec.birth_year = out_ch.out_birth_year;
      got.rec.name_key   = out_ch.out_name_key;
      got.entry_valid    = out_ch.entry_valid;
      got.last_of_run    = out_ch.last_of_run;
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("tb_top: unexpected word: %s", word_text(got));
      end else begin
        want = pending_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("tb_top: word mismatch, expected %s", word_text(want));
            $display("tb_top:                  actual %s", word_text(got));
          end
        end
      end
      n = rx_stalls_on ? $urandom_range(0, 11) : 0;
      rx_hold      <= n;
      out_ch.ready <= (n == 0);
    end else if (rx_hold > 1) begin
      rx_hold <= rx_hold - 1;
    end else begin
      rx_hold      <= 0;
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_word(input logic [1:0] op, input rec_t r);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.opcode     <= op;
    in_ch.record_id  <= r.record_id;
    in_ch.height     <= r.height;
    in_ch.weight     <= r.weight;
    in_ch.birth_year <= r.birth_year;
    in_ch.name_key   <= r.name_key;
    do @(posedge clk_i); while (!in_ch.ready);
    case (op)
      OP_INSERT: place_record(r);
      OP_EMIT:   list_kept_words();
      OP_CLEAR:  kept_fill = 0;
      default: ;
    endcase
  endtask

  task automatic wait_store_idle();
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (HOLD_OFF) @(posedge clk_i);
  endtask

  // write the limit if asked, then read it back
  task automatic limit_reg_access(input bit do_write, input logic [LIMIT_W-1:0] value);
    psel  <= 1'b1;
    paddr <= KEPT_LIMIT_ADDR;
    if (do_write) begin
      pwrite  <= 1'b1;
      pwdata  <= PDATA_W'(value);
      penable <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      kept_k = value;
    end
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[LIMIT_W-1:0] !== kept_k) begin
      mismatches++;
      if (mismatches <= 10)
        $display("tb_top: limit readback expected %0d actual %0d", kept_k,
                 prdata[LIMIT_W-1:0]);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_value();
    limit_reg_access(1'b0, '0);
  endtask

  task automatic test_empty_store();
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    send_word(OP_EMIT, rand_rec());
    send_word(OP_CLEAR, rand_rec());
    send_word(OP_UNUSED, rand_rec());
    send_word(OP_EMIT, rand_rec());
    wait_store_idle();
  endtask

  task automatic test_sorted_insert();
    send_word(OP_INSERT, mk_rec(1, 170, 70, 2000, 64'd5));
    send_word(OP_INSERT, mk_rec(2, 171, 71, 2000, 64'd5));
    send_word(OP_INSERT, mk_rec(3, 160, 60, 1999, '1));
    send_word(OP_INSERT, mk_rec(4, 150, 50, 2000, 64'h8000_0000_0000_0000));
    send_word(OP_INSERT, mk_rec(5, 151, 51, 2000, 64'h7FFF_FFFF_FFFF_FFFF));
    send_word(OP_INSERT, mk_rec(4095, 255, 255, 4095, '1));
    send_word(OP_INSERT, mk_rec(0, 0, 0, 0, 64'h0));
    send_word(OP_INSERT, mk_rec(8, 180, 80, 2001, 64'd0));
    send_word(OP_INSERT, mk_rec(9, 181, 81, 2001, 64'd1));
    send_word(OP_INSERT, mk_rec(10, 182, 82, 2001, 64'd2));
    // store full: an equal key drops, a smaller one pushes the last out
    send_word(OP_INSERT, mk_rec(11, 190, 90, 4095, '1));
    send_word(OP_INSERT, mk_rec(12, 191, 91, 3000, 64'd7));
    send_word(OP_EMIT, rand_rec());
    send_word(OP_UNUSED, mk_rec(4095, 255, 255, 4095, '1));
    send_word(OP_EMIT, rand_rec());
    send_word(OP_CLEAR, rand_rec());
    send_word(OP_EMIT, rand_rec());
    wait_store_idle();
  endtask

  task automatic test_random_limits();
    logic [LIMIT_W-1:0] k;
    int                 sent;
    int                 pick;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_store_idle();
      case (p)
        0: k = 5'd16;
        1: k = 5'd0;
        2: k = 5'd31;
        3: k = 5'd3;
        4: k = 5'd1;
        5: k = LIMIT_RESET;
        default: k = LIMIT_W'($urandom_range(0, 31));
      endcase
      limit_reg_access(1'b1, k);
      tx_gaps_on   = p[0];
      rx_stalls_on = p[1];
      sent = 0;
      while (sent < RANDOM_ITEMS / RANDOM_PHASES) begin
        pick = $urandom_range(0, 99);
        if (pick < 68) begin
          send_word(OP_INSERT, rand_rec());
          sent++;
        end else if (pick < 86) begin
          send_word(OP_EMIT, rand_rec());
          sent++;
        end else if (pick < 90) begin
          send_word(OP_CLEAR, rand_rec());
          sent++;
        end else if (pick < 95) begin
          send_word(OP_UNUSED, rand_rec());
        end else begin
          wait_store_idle();
        end
      end
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.opcode     <= OP_INSERT;
    in_ch.record_id  <= '0;
    in_ch.height     <= '0;
    in_ch.weight     <= '0;
    in_ch.birth_year <= '0;
    in_ch.name_key   <= '0;
    kept_fill    = 0;
    kept_k       = LIMIT_RESET;
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_value();
    test_empty_store();
    test_sorted_insert();
    test_random_limits();

    wait_store_idle();
    if (pending_words.size() != 0) begin
      mismatches += pending_words.size();
      $display("tb_top: %0d expected words never arrived", pending_words.size());
    end
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
